/* hdl/hpoc_pkg.sv */
// Shared constants, microcode types and step addresses of the order count calculator.
package hpoc_pkg;

    localparam int CYCLE_MAX = 256;
    localparam int ADDR_W    = (CYCLE_MAX > 1) ? $clog2(CYCLE_MAX) : 1;
    localparam int LEN_W     = $clog2(CYCLE_MAX + 1);
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int UPC_W     = 4;

    localparam logic [1:0] TYPE_LSB   = 2'd0;
    localparam logic [1:0] TYPE_CYCLE = 2'd1;
    localparam logic [1:0] TYPE_TWICE = 2'd2;
    localparam logic [1:0] TYPE_FRAME = 2'd3;

    localparam logic [1:0] CFG_TYPE       = 2'd0;
    localparam logic [1:0] CFG_LOG2_LSB   = 2'd1;
    localparam logic [1:0] CFG_LOG2_FRAME = 2'd2;
    localparam logic [1:0] CFG_CYCLE_LEN  = 2'd3;

    localparam logic [UPC_W-1:0] U_WAIT    = 4'd0;
    localparam logic [UPC_W-1:0] U_PREP    = 4'd1;
    localparam logic [UPC_W-1:0] U_SIMPLE  = 4'd2;
    localparam logic [UPC_W-1:0] U_ABSF    = 4'd3;
    localparam logic [UPC_W-1:0] U_DIVINIT = 4'd4;
    localparam logic [UPC_W-1:0] U_DIVSTEP = 4'd5;
    localparam logic [UPC_W-1:0] U_SCAN    = 4'd6;
    localparam logic [UPC_W-1:0] U_MUL     = 4'd7;
    localparam logic [UPC_W-1:0] U_ACCUM   = 4'd8;
    localparam logic [UPC_W-1:0] U_DELTA   = 4'd9;
    localparam logic [UPC_W-1:0] U_OUTWAIT = 4'd10;
    localparam logic [UPC_W-1:0] U_FINISH  = 4'd11;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_PREP    = 4'd1,
        OP_SIMPLE  = 4'd2,
        OP_ABSF    = 4'd3,
        OP_DIVINIT = 4'd4,
        OP_DIVSTEP = 4'd5,
        OP_SCAN    = 4'd6,
        OP_MUL     = 4'd7,
        OP_ACCUM   = 4'd8,
        OP_DELTA   = 4'd9,
        OP_FINISH  = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_START  = 3'd2,
        C_TYPE1     = 3'd3,
        C_SKIP      = 3'd4,
        C_DIV_MORE  = 3'd5,
        C_SCAN_MORE = 3'd6,
        C_OUT_BUSY  = 3'd7
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic type1;
        logic skip;
        logic div_more;
        logic scan_more;
        logic out_busy;
    } t_flags;

endpackage

/* hdl/h264_poc_calculator.sv */
// Top level of the picture order count calculator: datapath, table and handshakes.
//
//  Channel   Direction  Handshake                  Payload
//  in        to block   i_in_valid / o_in_stall    func, table_slot, table_word, frame_number,
//                                                  idr_flag, ref_flag, lsb_value, delta_count
//  out       from block o_out_valid / i_out_stall  order_count
//  cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  A load request writes the table word and leaves the sequencer waiting. Types 0, 2 and 3 give
//  their result from the simple step; type 1 adds a 32-step divider and a len-word scan unless skipped.
//  The table RAM has one read port, which sets the length of the type 1 scan.
//  Reset is synchronous: it clears the sequencer, picture state and valid flags and resets the config.
//  A finished result waits in the output register while the next request is taken.
//  While an earlier result waits on i_out_stall, the sequencer holds before writing the new one.
module h264_poc_calculator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [7:0]         i_table_slot,
    input  logic signed [31:0] i_table_word,
    input  logic [15:0]        i_frame_number,
    input  logic               i_idr_flag,
    input  logic               i_ref_flag,
    input  logic [15:0]        i_lsb_value,
    input  logic signed [31:0] i_delta_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_order_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import hpoc_pkg::*;

    t_ctrl            w_ctrl;
    t_flags           w_flags;
    logic [UPC_W-1:0] r_upc;

    logic [1:0]  r_cfg_type;
    logic [4:0]  r_cfg_log2_lsb;
    logic [4:0]  r_cfg_log2_frame;
    logic [7:0]  r_cfg_len;

    logic [31:0] r_prev_msb;
    logic [15:0] r_prev_lsb;
    logic [31:0] r_frame_offset;
    logic [15:0] r_prev_frame;

    logic [15:0] r_frame;
    logic        r_idr;
    logic        r_ref;
    logic [15:0] r_lsb;
    logic [31:0] r_delta;

    logic [31:0] r_tmp;
    logic [31:0] r_res;
    logic [31:0] r_absf;
    logic [31:0] r_quo;
    logic [LEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] r_rd_idx;
    logic        r_rd_valid;
    logic [31:0] r_sum;
    logic [31:0] r_acc;
    logic [31:0] r_prod;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic             w_in_acc;
    logic             w_load;
    logic [LEN_W-1:0] w_len;
    logic [31:0]      w_maxl;
    logic [31:0]      w_half;
    logic [31:0]      w_maxf;
    logic [31:0]      w_msb;
    logic [31:0]      w_next_fo;
    logic [LEN_W:0]   w_shift;
    logic             w_ge;
    logic [31:0]      w_rd_data;
    logic             w_wr_en;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_load      = w_in_acc && !i_func;
    assign w_wr_en     = w_load && (32'(i_table_slot) < CYCLE_MAX);
    assign o_in_stall  = (r_upc != U_WAIT);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_order_count = $signed(r_out);

    assign w_len = (32'(r_cfg_len) > CYCLE_MAX) ? LEN_W'(CYCLE_MAX) : LEN_W'(r_cfg_len);

    always_comb begin
        w_maxl = 32'd1 << r_cfg_log2_lsb;
        w_half = (r_cfg_log2_lsb == 5'd0) ? 32'd0 : (32'd1 << (r_cfg_log2_lsb - 5'd1));
        w_maxf = 32'd1 << r_cfg_log2_frame;
        if (r_idr) begin
            w_msb = 32'd0;
        end else if ((r_lsb < r_prev_lsb) && (32'(r_prev_lsb - r_lsb) >= w_half)) begin
            w_msb = r_prev_msb + w_maxl;
        end else if ((r_lsb > r_prev_lsb) && (32'(r_lsb - r_prev_lsb) > w_half)) begin
            w_msb = r_prev_msb - w_maxl;
        end else begin
            w_msb = r_prev_msb;
        end
        if (r_idr) begin
            w_next_fo = 32'd0;
        end else if (r_prev_frame > r_frame) begin
            w_next_fo = r_frame_offset + w_maxf;
        end else begin
            w_next_fo = r_frame_offset;
        end
        w_shift = {r_rem, r_quo[31]};
        w_ge    = (w_shift >= {1'b0, w_len});
    end

    always_comb begin
        w_flags.start     = w_in_acc && i_func;
        w_flags.type1     = (r_cfg_type == TYPE_CYCLE);
        w_flags.skip      = (r_absf == 32'd0) || r_absf[31];
        w_flags.div_more  = (r_cnt != CNT_W'(DIV_STEPS - 1));
        w_flags.scan_more = (r_idx != w_len) || r_rd_valid;
        w_flags.out_busy  = r_out_valid && i_out_stall;
    end

    hpoc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_upc   (r_upc)
    );

    hpoc_ram #(
        .WIDTH (32),
        .DEPTH (CYCLE_MAX)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_table_slot[ADDR_W-1:0]),
        .i_wr_data (i_table_word),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_type       <= TYPE_LSB;
            r_cfg_log2_lsb   <= 5'd4;
            r_cfg_log2_frame <= 5'd4;
            r_cfg_len        <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TYPE:       r_cfg_type       <= i_cfg_data[1:0];
                CFG_LOG2_LSB:   r_cfg_log2_lsb   <= i_cfg_data[4:0];
                CFG_LOG2_FRAME: r_cfg_log2_frame <= i_cfg_data[4:0];
                CFG_CYCLE_LEN:  r_cfg_len        <= i_cfg_data;
                default:        r_cfg_type       <= r_cfg_type;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flags.start) begin
            r_frame <= i_frame_number;
            r_idr   <= i_idr_flag;
            r_ref   <= i_ref_flag;
            r_lsb   <= i_lsb_value;
            r_delta <= $unsigned(i_delta_count);
        end
        case (w_ctrl.op)
            OP_PREP: begin
                r_tmp <= w_msb;
            end
            OP_SIMPLE: begin
                case (r_cfg_type)
                    TYPE_LSB:   r_res <= r_tmp + 32'(r_lsb);
                    TYPE_TWICE: r_res <= r_idr ? 32'd0 :
                                         ((r_frame_offset + 32'(r_frame)) << 1);
                    TYPE_FRAME: r_res <= 32'(r_frame);
                    default:    r_res <= 32'd0;
                endcase
            end
            OP_ABSF: begin
                r_absf <= (w_len != '0) ? r_frame_offset + 32'(r_frame) : 32'd0;
                r_sum  <= 32'd0;
                r_acc  <= 32'd0;
            end
            OP_DIVINIT: begin
                r_quo <= r_absf - 32'd1;
                r_rem <= '0;
                r_cnt <= '0;
                r_idx <= '0;
            end
            OP_DIVSTEP: begin
                r_quo <= {r_quo[30:0], w_ge};
                r_rem <= w_ge ? LEN_W'(w_shift - {1'b0, w_len}) : LEN_W'(w_shift);
                r_cnt <= r_cnt + 1'b1;
            end
            OP_SCAN: begin
                if (r_idx != w_len) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_rd_idx <= r_idx;
                if (r_rd_valid) begin
                    r_sum <= r_sum + w_rd_data;
                    if (r_rd_idx <= r_rem) begin
                        r_acc <= r_acc + w_rd_data;
                    end
                end
            end
            OP_MUL: begin
                r_prod <= r_quo * r_sum;
            end
            OP_ACCUM: begin
                r_acc <= r_acc + r_prod;
            end
            OP_DELTA: begin
                r_res <= r_acc + r_delta;
            end
            OP_FINISH: begin
                r_out <= r_res;
            end
            default: begin
                r_tmp <= r_tmp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_msb     <= 32'd0;
            r_prev_lsb     <= 16'd0;
            r_frame_offset <= 32'd0;
            r_prev_frame   <= 16'd0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_valid <= (w_ctrl.op == OP_SCAN) && (r_idx != w_len);
            if ((w_ctrl.op == OP_PREP) &&
                ((r_cfg_type == TYPE_CYCLE) || (r_cfg_type == TYPE_TWICE))) begin
                r_frame_offset <= w_next_fo;
            end
            if ((w_ctrl.op == OP_SIMPLE) && (r_cfg_type == TYPE_LSB)) begin
                if (r_ref) begin
                    r_prev_msb <= r_tmp;
                    r_prev_lsb <= r_lsb;
                end else if (r_idr) begin
                    r_prev_msb <= 32'd0;
                    r_prev_lsb <= 16'd0;
                end
            end
            if (w_ctrl.op == OP_FINISH) begin
                r_out_valid  <= 1'b1;
                r_prev_frame <= r_frame;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == U_FINISH) |-> !r_out_valid)
        else $error("result register loaded while a result is pending");

    a_rise_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_upc == U_FINISH))
        else $error("result valid without a finishing step");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(r_upc == U_SCAN))
        else $error("table read data valid outside the scan");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_upc == U_SCAN) && $past(r_upc == U_DIVSTEP)) |-> (r_cnt == '0))
        else $error("divider left before all steps were done");

endmodule

/* hdl/hpoc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module hpoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/hpoc_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module hpoc_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hpoc_pkg::t_flags          i_flags,
    output hpoc_pkg::t_ctrl           o_ctrl,
    output logic [hpoc_pkg::UPC_W-1:0] o_upc
);
    import hpoc_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl            w_ctrl;
    logic             w_take;

    function automatic t_ctrl ucode(input logic [UPC_W-1:0] addr);
        t_ctrl c;
        c = '{op: OP_NONE, cond: C_ALWAYS, target: U_WAIT};
        case (addr)
            U_WAIT:    c = '{op: OP_NONE,    cond: C_NO_START,  target: U_WAIT};
            U_PREP:    c = '{op: OP_PREP,    cond: C_TYPE1,     target: U_ABSF};
            U_SIMPLE:  c = '{op: OP_SIMPLE,  cond: C_ALWAYS,    target: U_OUTWAIT};
            U_ABSF:    c = '{op: OP_ABSF,    cond: C_NEVER,     target: U_WAIT};
            U_DIVINIT: c = '{op: OP_DIVINIT, cond: C_SKIP,      target: U_DELTA};
            U_DIVSTEP: c = '{op: OP_DIVSTEP, cond: C_DIV_MORE,  target: U_DIVSTEP};
            U_SCAN:    c = '{op: OP_SCAN,    cond: C_SCAN_MORE, target: U_SCAN};
            U_MUL:     c = '{op: OP_MUL,     cond: C_NEVER,     target: U_WAIT};
            U_ACCUM:   c = '{op: OP_ACCUM,   cond: C_NEVER,     target: U_WAIT};
            U_DELTA:   c = '{op: OP_DELTA,   cond: C_NEVER,     target: U_WAIT};
            U_OUTWAIT: c = '{op: OP_NONE,    cond: C_OUT_BUSY,  target: U_OUTWAIT};
            U_FINISH:  c = '{op: OP_FINISH,  cond: C_ALWAYS,    target: U_WAIT};
            default:   c = '{op: OP_NONE,    cond: C_ALWAYS,    target: U_WAIT};
        endcase
        return c;
    endfunction

    always_comb begin
        w_ctrl = ucode(r_upc);
        case (w_ctrl.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_START:  w_take = !i_flags.start;
            C_TYPE1:     w_take = i_flags.type1;
            C_SKIP:      w_take = i_flags.skip;
            C_DIV_MORE:  w_take = i_flags.div_more;
            C_SCAN_MORE: w_take = i_flags.scan_more;
            C_OUT_BUSY:  w_take = i_flags.out_busy;
            default:     w_take = 1'b1;
        endcase
        n_upc = w_take ? w_ctrl.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_upc  = r_upc;

endmodule
